FILE: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the polygon plane clipper
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    localparam int COORD_W  = 16;
    localparam int COUNT_W  = 6;
    localparam int FRAC_W   = 14;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_NORMAL_X     = 2'd0;
    localparam logic [1:0] CFG_NORMAL_Y     = 2'd1;
    localparam logic [1:0] CFG_NORMAL_Z     = 2'd2;
    localparam logic [1:0] CFG_PLANE_OFFSET = 2'd3;

    // classified vertex handed from front to back
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] dot;
        logic                      in_plane;
        logic                      last;
    } item_t;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_EDGE,
        ST_CROSS,
        ST_DIV,
        ST_MUL,
        ST_POINT,
        ST_CUR,
        ST_ADVANCE,
        ST_FINISH
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/pps_front.sv
// ----------------------------------------------------------------------------
// pps_front
// accepts vertices, forms the plane dot product and the inside flag
// ----------------------------------------------------------------------------
`default_nettype none

module pps_front
    import pps_pkg::*;
#(
    parameter int DOT_SHIFT = 15
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] in_x,
    input  wire logic signed [COORD_W-1:0] in_y,
    input  wire logic signed [COORD_W-1:0] in_z,
    input  wire logic                      in_last,
    input  wire logic signed [COORD_W-1:0] normal_x,
    input  wire logic signed [COORD_W-1:0] normal_y,
    input  wire logic signed [COORD_W-1:0] normal_z,
    input  wire logic signed [COORD_W-1:0] plane_offset,
    output logic                           push_valid,
    input  wire logic                      push_ready,
    output item_t                          push_item
);

    logic                      s1_valid_reg;
    logic signed [31:0]        px_reg;
    logic signed [31:0]        py_reg;
    logic signed [31:0]        pz_reg;
    logic signed [COORD_W-1:0] vx_reg;
    logic signed [COORD_W-1:0] vy_reg;
    logic signed [COORD_W-1:0] vz_reg;
    logic                      last_reg;
    logic signed [33:0]        sum;
    logic signed [COORD_W-1:0] dot;
    logic                      load;

    assign in_ready   = !s1_valid_reg || push_ready;
    assign load       = in_valid && in_ready;
    assign push_valid = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= in_x * normal_x;
            py_reg   <= in_y * normal_y;
            pz_reg   <= in_z * normal_z;
            vx_reg   <= in_x;
            vy_reg   <= in_y;
            vz_reg   <= in_z;
            last_reg <= in_last;
        end
    end

    // floor shift and wrap to 16 bits is a plain bit slice
    always_comb
    begin
        sum = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
        dot = sum[DOT_SHIFT+COORD_W-1:DOT_SHIFT];
        push_item.x        = vx_reg;
        push_item.y        = vy_reg;
        push_item.z        = vz_reg;
        push_item.dot      = dot;
        push_item.in_plane = dot >= plane_offset;
        push_item.last     = last_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/pps_fifo.sv
// ----------------------------------------------------------------------------
// pps_fifo
// short queue of classified vertices between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pps_fifo
    import pps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_item
);

    item_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pps_div.sv
// ----------------------------------------------------------------------------
// pps_div
// bit-serial signed divider for the intersection parameter
// ----------------------------------------------------------------------------
`default_nettype none

module pps_div
    import pps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [COORD_W:0]   num,
    input  wire logic signed [COORD_W:0]   den,
    output logic                           done,
    output logic signed [COORD_W-1:0]      t
);

    localparam int QW = COORD_W + 1 + FRAC_W;

    logic                      busy_reg;
    logic                      done_reg;
    logic [4:0]                cnt_reg;
    logic [COORD_W+1:0]        rem_reg;
    logic [QW-1:0]             qr_reg;
    logic [COORD_W:0]          dmag_reg;
    logic                      neg_reg;
    logic signed [COORD_W-1:0] t_reg;
    logic [COORD_W:0]          nmag;
    logic [COORD_W:0]          dmag;
    logic [COORD_W+1:0]        rem_sh;
    logic                      ge;
    logic [QW-1:0]             q_new;

    assign nmag   = num[COORD_W] ? 17'(-num) : 17'(num);
    assign dmag   = den[COORD_W] ? 17'(-den) : 17'(den);
    assign rem_sh = {rem_reg[COORD_W:0], qr_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, dmag_reg};
    assign q_new  = {qr_reg[QW-2:0], ge};
    assign done   = done_reg;
    assign t      = t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'(QW - 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            qr_reg   <= {nmag, {FRAC_W{1'b0}}};
            dmag_reg <= dmag;
            neg_reg  <= num[COORD_W] ^ den[COORD_W];
            t_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sh - {1'b0, dmag_reg} : rem_sh;
            qr_reg  <= q_new;
            // only the low 16 quotient bits survive the wrap
            if (cnt_reg == '0)
            begin
                t_reg <= neg_reg ? -q_new[COORD_W-1:0] : q_new[COORD_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pps_back.sv
// ----------------------------------------------------------------------------
// pps_back
// edge sequencer: emits kept vertices, intersections and the end marker
// ----------------------------------------------------------------------------
`default_nettype none

module pps_back
    import pps_pkg::*;
#(
    parameter int MAX_OUT_VERTICES = 63
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pop_valid,
    output logic                           pop_ready,
    input  wire item_t                     pop_item,
    input  wire logic signed [COORD_W-1:0] plane_offset,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [55:0]                    m_tdata,
    output logic                           m_tlast
);

    localparam int CAP_INT = (MAX_OUT_VERTICES < 63) ? MAX_OUT_VERTICES : 63;
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);

    back_state_t               state_reg;
    back_state_t               state_next;
    item_t                     cur_reg;
    item_t                     first_reg;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic signed [COORD_W-1:0] prev_z_reg;
    logic signed [COORD_W-1:0] prev_dot_reg;
    logic                      prev_in_reg;
    logic                      have_first_reg;
    logic                      closing_reg;
    logic [1:0]                cc_reg;
    logic [COUNT_W-1:0]        ec_reg;
    logic signed [32:0]        prod_x_reg;
    logic signed [32:0]        prod_y_reg;
    logic signed [32:0]        prod_z_reg;
    logic                      ov_reg;
    logic                      olast_reg;
    logic [55:0]               odata_reg;

    logic signed [COORD_W-1:0] e_x;
    logic signed [COORD_W-1:0] e_y;
    logic signed [COORD_W-1:0] e_z;
    logic signed [COORD_W-1:0] e_dot;
    logic                      e_in;
    logic                      slot_free;
    logic                      crossing;
    logic                      emit;
    logic                      emit_end;
    logic [47:0]               emit_xyz;
    logic                      div_start;
    logic                      div_done;
    logic signed [COORD_W-1:0] div_t;
    logic signed [COORD_W:0]   div_num;
    logic signed [COORD_W:0]   div_den;
    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic signed [COORD_W:0]   diff_z;
    logic signed [COORD_W-1:0] pt_x;
    logic signed [COORD_W-1:0] pt_y;
    logic signed [COORD_W-1:0] pt_z;

    // the closing edge runs back to the first vertex
    always_comb
    begin
        e_x   = closing_reg ? first_reg.x   : cur_reg.x;
        e_y   = closing_reg ? first_reg.y   : cur_reg.y;
        e_z   = closing_reg ? first_reg.z   : cur_reg.z;
        e_dot = closing_reg ? first_reg.dot : cur_reg.dot;
        e_in  = closing_reg ? (first_reg.dot >= plane_offset) : cur_reg.in_plane;
    end

    assign slot_free = !ov_reg || m_tready;
    assign crossing  = prev_in_reg != e_in;
    assign div_num   = 17'(plane_offset) - 17'(prev_dot_reg);
    assign div_den   = 17'(e_dot) - 17'(prev_dot_reg);
    assign diff_x    = 17'(e_x) - 17'(prev_x_reg);
    assign diff_y    = 17'(e_y) - 17'(prev_y_reg);
    assign diff_z    = 17'(e_z) - 17'(prev_z_reg);
    assign pt_x      = prev_x_reg + prod_x_reg[29:14];
    assign pt_y      = prev_y_reg + prod_y_reg[29:14];
    assign pt_z      = prev_z_reg + prod_z_reg[29:14];

    pps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .t     (div_t)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FETCH:
            begin
                if (pop_valid)
                begin
                    if (!have_first_reg || cc_reg == 2'd3)
                    begin
                        state_next = ST_ADVANCE;
                    end
                    else if (cc_reg == 2'd2)
                    begin
                        state_next = ST_CUR;
                    end
                    else
                    begin
                        state_next = ST_EDGE;
                    end
                end
            end
            ST_EDGE:
            begin
                if (!prev_in_reg || slot_free)
                begin
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                if (crossing)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = closing_reg ? ST_FINISH : ST_ADVANCE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_POINT;
            end
            ST_POINT:
            begin
                if (slot_free)
                begin
                    if (cc_reg == 2'd1 && e_in && !closing_reg)
                    begin
                        state_next = ST_CUR;
                    end
                    else
                    begin
                        state_next = closing_reg ? ST_FINISH : ST_ADVANCE;
                    end
                end
            end
            ST_CUR:
            begin
                if (slot_free)
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                if (!cur_reg.last)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = (cc_reg < 2'd2) ? ST_EDGE : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        emit_end  = 1'b0;
        emit_xyz  = '0;
        unique case (state_reg)
            ST_FETCH:
            begin
                pop_ready = 1'b1;
            end
            ST_EDGE:
            begin
                emit     = prev_in_reg && slot_free;
                emit_xyz = {prev_z_reg, prev_y_reg, prev_x_reg};
            end
            ST_CROSS:
            begin
                div_start = crossing;
            end
            ST_POINT:
            begin
                emit     = slot_free;
                emit_xyz = {pt_z, pt_y, pt_x};
            end
            ST_CUR:
            begin
                emit     = slot_free;
                emit_xyz = {cur_reg.z, cur_reg.y, cur_reg.x};
            end
            ST_FINISH:
            begin
                emit     = slot_free;
                emit_end = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FETCH;
            have_first_reg <= 1'b0;
            closing_reg    <= 1'b0;
            cc_reg         <= '0;
            ec_reg         <= '0;
            prev_in_reg    <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
            if (emit)
            begin
                ov_reg <= 1'b1;
                if (!emit_end && ec_reg < CAP)
                begin
                    ec_reg <= ec_reg + 1'b1;
                end
            end
            if (state_reg == ST_FETCH && pop_valid)
            begin
                closing_reg <= 1'b0;
                if (!have_first_reg)
                begin
                    have_first_reg <= 1'b1;
                    cc_reg         <= '0;
                    ec_reg         <= '0;
                end
            end
            if (state_reg == ST_POINT && slot_free)
            begin
                cc_reg <= (cc_reg == 2'd1 && !e_in) ? 2'd3 : cc_reg + 1'b1;
            end
            if (state_reg == ST_ADVANCE)
            begin
                prev_in_reg <= cur_reg.in_plane;
                if (cur_reg.last && cc_reg < 2'd2)
                begin
                    closing_reg <= 1'b1;
                end
            end
            if (state_reg == ST_FINISH && slot_free)
            begin
                have_first_reg <= 1'b0;
                closing_reg    <= 1'b0;
                cc_reg         <= '0;
                ec_reg         <= '0;
                prev_in_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH && pop_valid)
        begin
            cur_reg <= pop_item;
            if (!have_first_reg)
            begin
                first_reg <= pop_item;
            end
        end
        if (state_reg == ST_ADVANCE)
        begin
            prev_x_reg   <= cur_reg.x;
            prev_y_reg   <= cur_reg.y;
            prev_z_reg   <= cur_reg.z;
            prev_dot_reg <= cur_reg.dot;
        end
        if (state_reg == ST_MUL)
        begin
            prod_x_reg <= diff_x * div_t;
            prod_y_reg <= diff_y * div_t;
            prod_z_reg <= diff_z * div_t;
        end
        if (emit)
        begin
            olast_reg <= emit_end;
            if (emit_end)
            begin
                odata_reg <= {1'b0, (ec_reg > 6'd1), ec_reg, 48'b0};
            end
            else
            begin
                odata_reg <= {8'b0, emit_xyz};
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

FILE: rtl/polygon_plane_clipper.sv
// ----------------------------------------------------------------------------
// polygon_plane_clipper
// clips a streamed polygon against one configured plane
// ----------------------------------------------------------------------------
// Vertices enter one per request, the final one flagged by tlast; output is
// the clipped vertex list followed by one end marker (tlast high) carrying
// the vertex count and a valid flag. A front stage forms each vertex's dot
// product from registered partial products and queues it; the back sequencer
// then steps through each edge of the polygon, and every plane crossing adds
// a division by the one-bit-per-cycle divider that finds the intersection
// parameter. One result is delivered per cycle at most.
// Configuration may be written only while no polygon is in flight.
`default_nettype none

module polygon_plane_clipper
    import pps_pkg::*;
#(
    parameter int DOT_SHIFT        = 15,
    parameter int MAX_OUT_VERTICES = 63
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // vertex_x, vertex_y, vertex_z
    input  wire logic        s_tlast,   // last_vertex
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_x, out_y, out_z, vertex_count, polygon_valid
    output logic             m_tlast,   // is_end
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic signed [COORD_W-1:0] normal_x_reg;
    logic signed [COORD_W-1:0] normal_y_reg;
    logic signed [COORD_W-1:0] normal_z_reg;
    logic signed [COORD_W-1:0] offset_reg;
    logic                      push_valid;
    logic                      push_ready;
    item_t                     push_item;
    logic                      pop_valid;
    logic                      pop_ready;
    item_t                     pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= '0;
            normal_y_reg <= '0;
            normal_z_reg <= '0;
            offset_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NORMAL_X:     normal_x_reg <= cfg_data;
                CFG_NORMAL_Y:     normal_y_reg <= cfg_data;
                CFG_NORMAL_Z:     normal_z_reg <= cfg_data;
                CFG_PLANE_OFFSET: offset_reg   <= cfg_data;
                default:          offset_reg   <= offset_reg;
            endcase
        end
    end

    pps_front #(
        .DOT_SHIFT (DOT_SHIFT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_x         (s_tdata[15:0]),
        .in_y         (s_tdata[31:16]),
        .in_z         (s_tdata[47:32]),
        .in_last      (s_tlast),
        .normal_x     (normal_x_reg),
        .normal_y     (normal_y_reg),
        .normal_z     (normal_z_reg),
        .plane_offset (offset_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    pps_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pps_back #(
        .MAX_OUT_VERTICES (MAX_OUT_VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .plane_offset (offset_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// port-level checks on the clipper output stream
// ----------------------------------------------------------------------------
`default_nettype none

module pps_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // end marker carries no coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[47:0] == 48'b0)
        else $error("end marker with coordinates");

    // vertex results carry no count or valid flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[55:48] == 8'b0)
        else $error("vertex result with count bits");

    // a valid polygon has more than one vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tdata[54] |-> m_tdata[53:48] > 6'd1)
        else $error("polygon valid with too few vertices");

endmodule

bind polygon_plane_clipper pps_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: test/tb_polygon_plane_clipper.sv
// ----------------------------------------------------------------------------
// tb_polygon_plane_clipper
// self-checking bench for the single-plane polygon clipper
// ----------------------------------------------------------------------------
// Polygons are streamed in as vertex requests under several plane settings.
// A behavioural clipper in the bench predicts every output vertex and end
// marker, and the monitor compares each one in order. Both sides of the
// stream idle at random, and the output side also holds off for long spells.
`default_nettype none

module tb_polygon_plane_clipper;
    import pps_pkg::*;

    typedef struct packed {
        logic               last;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } vtx_req_t;

    typedef struct packed {
        logic               is_end;
        logic               valid;
        logic [5:0]         count;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } clip_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    vtx_req_t  pending_vertices[$];
    clip_res_t expected_vertices[$];

    // plane and polygon state of the predictor
    logic signed [15:0] pl_nx, pl_ny, pl_nz, pl_off;
    logic signed [15:0] fx, fy, fz, fdot, px, py, pz, pdot;
    logic               pin, started;
    int unsigned        crossings, emitted;

    int  mismatches;
    int  cycle_count;
    int  burst_left, gap_left, hold_left;

    polygon_plane_clipper u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic signed [15:0] plane_dot(logic signed [15:0] x,
                                                     logic signed [15:0] y,
                                                     logic signed [15:0] z);
        longint s;
        s = longint'(x) * pl_nx + longint'(y) * pl_ny + longint'(z) * pl_nz;
        return 16'(s >>> 15);
    endfunction

    function automatic logic signed [15:0] lerp16(logic signed [15:0] a,
                                                  logic signed [15:0] b,
                                                  longint t);
        longint r;
        r = longint'(a) + (((longint'(b) - longint'(a)) * t) >>> 14);
        return 16'(r);
    endfunction

    task automatic emit_vertex(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        clip_res_t r;
        r = '0;
        r.x = x;
        r.y = y;
        r.z = z;
        expected_vertices.push_back(r);
        if (emitted < 63) emitted++;
    endtask

    task automatic clip_edge(logic signed [15:0] nx, logic signed [15:0] ny,
                             logic signed [15:0] nz, logic signed [15:0] nd,
                             logic nin, bit closing);
        longint num, den, t;
        if (pin) emit_vertex(px, py, pz);
        if (pin != nin) begin
            num = longint'(pl_off) - longint'(pdot);
            den = longint'(nd) - longint'(pdot);
            t = 0;
            if (den != 0) t = (num * 16384) / den;
            // signed size cast wraps to 16 bits and sign-extends again
            t = longint'(16'(t));
            emit_vertex(lerp16(px, nx, t), lerp16(py, ny, t), lerp16(pz, nz, t));
            crossings++;
            if (crossings == 2) begin
                if (nin) begin
                    if (!closing) emit_vertex(nx, ny, nz);
                end
                else crossings = 3;
            end
        end
    endtask

    task automatic predict_clip(vtx_req_t v);
        logic signed [15:0] d;
        logic               in;
        clip_res_t          m;
        d  = plane_dot(v.x, v.y, v.z);
        in = (d >= pl_off);
        if (!started) begin
            fx = v.x; fy = v.y; fz = v.z; fdot = d;
            started = 1'b1;
            crossings = 0;
            emitted = 0;
        end
        else if (crossings == 2) emit_vertex(v.x, v.y, v.z);
        else if (crossings < 2) clip_edge(v.x, v.y, v.z, d, in, 1'b0);
        px = v.x; py = v.y; pz = v.z; pdot = d; pin = in;
        if (v.last) begin
            if (crossings < 2) clip_edge(fx, fy, fz, fdot, fdot >= pl_off, 1'b1);
            m = '0;
            m.is_end = 1'b1;
            m.count  = 6'(emitted);
            m.valid  = (emitted > 1);
            expected_vertices.push_back(m);
            started = 1'b0;
            crossings = 0;
            emitted = 0;
            pin = 1'b0;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic signed [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NORMAL_X: pl_nx  = val;
            CFG_NORMAL_Y: pl_ny  = val;
            CFG_NORMAL_Z: pl_nz  = val;
            default:      pl_off = val;
        endcase
    endtask

    task automatic set_plane(logic signed [15:0] nx, logic signed [15:0] ny,
                             logic signed [15:0] nz, logic signed [15:0] off);
        write_reg(CFG_NORMAL_X, nx);
        write_reg(CFG_NORMAL_Y, ny);
        write_reg(CFG_NORMAL_Z, nz);
        write_reg(CFG_PLANE_OFFSET, off);
    endtask

    // requests are predicted as they are queued; the block sees them in order
    task automatic queue_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z, logic last);
        vtx_req_t v;
        v.x = x; v.y = y; v.z = z; v.last = last;
        pending_vertices.push_back(v);
        predict_clip(v);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic queue_polygon(int n);
        for (int i = 0; i < n; i++)
            queue_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
    endtask

    task automatic drain();
        while (pending_vertices.size() != 0 || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready) void'(pending_vertices.pop_front());
            if (s_tvalid && !s_tready)
                ;
            else if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if ((pending_vertices.size() > (s_tvalid && s_tready ? 0 : 0))
                     && pending_vertices.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_vertices[0].z, pending_vertices[0].y,
                             pending_vertices[0].x};
                s_tlast  <= pending_vertices[0].last;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 8);
                end
                else burst_left <= burst_left - 1;
            end
            else s_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if ($urandom_range(0, 299) == 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(150, 400);
        end
        else m_tready <= (cycle_count % 23 < 15) || ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            clip_res_t got, exp_r;
            got = {m_tlast, m_tdata[54:0]};
            if (expected_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tlast=%0d data=%h", m_tlast, m_tdata);
            end
            else
            begin
                exp_r = expected_vertices.pop_front();
                if (got.is_end !== exp_r.is_end || got.x !== exp_r.x || got.y !== exp_r.y
                    || got.z !== exp_r.z || got.count !== exp_r.count
                    || got.valid !== exp_r.valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: exp end=%0d (%0d,%0d,%0d) cnt=%0d ok=%0d",
                               exp_r.is_end, exp_r.x, exp_r.y, exp_r.z, exp_r.count,
                               exp_r.valid);
                        $display(" got end=%0d (%0d,%0d,%0d) cnt=%0d ok=%0d",
                                 got.is_end, got.x, got.y, got.z,
                                 got.count, got.valid);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000)
        begin
            $display("polygon_plane_clipper verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NORMAL_X;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        pl_nx = 0; pl_ny = 0; pl_nz = 0; pl_off = 0;
        started = 1'b0; pin = 1'b0; crossings = 0; emitted = 0;
        fx = 0; fy = 0; fz = 0; fdot = 0; px = 0; py = 0; pz = 0; pdot = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // x axis plane through zero
        set_plane(16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_vertex(16'sd100, 16'sd5, 16'sd0, 1'b1);
        queue_vertex(-16'sd100, 16'sd5, 16'sd0, 1'b1);
        // four-vertex polygon crossing twice, last vertex outside so no tail is copied
        queue_vertex(-16'sd100, 16'sd0, 16'sd0, 1'b0);
        queue_vertex(16'sd100, 16'sd0, 16'sd0, 1'b0);
        queue_vertex(16'sd50, 16'sd80, 16'sd0, 1'b0);
        queue_vertex(-16'sd60, 16'sd70, 16'sd3, 1'b1);
        // second crossing on the closing edge
        queue_vertex(16'sd100, 16'sd0, 16'sd0, 1'b0);
        queue_vertex(-16'sd100, 16'sd9, 16'sd0, 1'b1);
        // coordinate extremes
        queue_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        queue_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        queue_vertex(16'sh7fff, 16'sh8000, 16'sh0000, 1'b1);
        drain();
        set_plane(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
        queue_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        queue_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
        drain();
        set_plane(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
        // all inside: long polygon saturates the count
        queue_polygon(70);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_plane(16'sh4000, -16'sh2000, 16'sh1000, 16'sd0);
                1: set_plane(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($signed($urandom_range(0, 400)) - 200));
                2: set_plane(16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0000);
                3: set_plane(16'sh8000, 16'sh3000, -16'sh5000, 16'sd100);
                default: set_plane(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            for (int n = 0; n < 72; )
            begin
                int k;
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                 : $urandom_range(3, 8);
                queue_polygon(k);
                n += k;
            end
            drain();
        end

        if (mismatches == 0)
            $display("polygon_plane_clipper verification clean");
        else
            $display("polygon_plane_clipper verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: polygon_plane_clipper.f
rtl/pps_pkg.sv
rtl/pps_front.sv
rtl/pps_fifo.sv
rtl/pps_div.sv
rtl/pps_back.sv
rtl/polygon_plane_clipper.sv
rtl/pps_checker.sv
test/tb_polygon_plane_clipper.sv
